FILE: rtl/core/mdrs_pkg.sv
`default_nettype none

package mdrs_pkg;

	// Field widths fixed by the interface.
	localparam int TYPE_W    = 4;
	localparam int COUNT_W   = 3;
	localparam int LEVEL_W   = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 4;
	localparam int NUM_TYPES = 6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_4 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_5 = 3'd6;

	// Operation codes of an input item.
	localparam logic OP_PUSH    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} mdrs_state_t;

	typedef struct packed {
		logic              operation;
		logic [TYPE_W-1:0] event_type;
	} mdrs_item_t;

	typedef struct packed {
		logic               command_valid;
		logic               motor_group;
		logic [TYPE_W-1:0]  requested_type;
		logic               served_from_queue;
		logic               push_dropped;
		logic [LEVEL_W-1:0] queue_level;
	} mdrs_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic push_wr;
		logic push_drop;
		logic cmd_step;
		logic pop;
	} mdrs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_is_cmd;
		logic fifo_full;
		logic fifo_empty;
	} mdrs_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/mdrs_ram.sv
`default_nettype none

module mdrs_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                          wr_data,
	input  wire logic                                      rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/mdrs_ctrl.sv
`default_nettype none

module mdrs_ctrl
	import mdrs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire mdrs_stat_t stat,
	output mdrs_cmd_t       cmd,
	output logic            busy,
	output logic            done
);

	mdrs_state_t state_q, state_d;
	logic        done_q, done_d;

	// State and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.push_wr   = !stat.op_is_cmd && !stat.fifo_full;
				cmd.push_drop = !stat.op_is_cmd && stat.fifo_full;
				cmd.cmd_step  = stat.op_is_cmd;
				cmd.pop       = stat.op_is_cmd && !stat.fifo_empty;
				done_d        = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

`ifndef SYNTHESIS
	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> done_q)
		else $error("result strobe missing after execute cycle");
	a_done_only_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe outside the idle state");
	a_capture_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (state_q == ST_IDLE))
		else $error("item captured while busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mdrs_dp.sv
`default_nettype none

module mdrs_dp
	import mdrs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TABLE_SIZE  = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mdrs_cmd_t             cmd,
	input  wire mdrs_item_t            item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_data,
	output mdrs_stat_t                 stat,
	output mdrs_result_t               result
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	// Configuration registers.
	logic [COUNT_W-1:0] count_q;
	logic [TYPE_W-1:0]  types_q [NUM_TYPES];

	// Scheduler state.
	logic               group_q;
	logic [2:0]         index_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [FW-1:0]      fill_q;
	mdrs_item_t         item_q;
	mdrs_result_t       result_q;
	logic [TYPE_W-1:0]  rd_data;

	// Next-state values.
	logic               group_d;
	logic [2:0]         index_d;
	logic [3:0]         index_inc;
	logic [COUNT_W-1:0] eff_count;
	logic [FW-1:0]      fill_d;
	logic [FW+4:0]      fill_ext;
	logic [TYPE_W-1:0]  table_type;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
			for (int i = 0; i < NUM_TYPES; i++) begin
				types_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				CFG_COUNT: begin
					count_q <= cfg_data[COUNT_W-1:0];
				end
				CFG_TYPE_0, CFG_TYPE_1, CFG_TYPE_2, CFG_TYPE_3, CFG_TYPE_4, CFG_TYPE_5: begin
					types_q[3'(cfg_index - CFG_TYPE_0)] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Effective table length: zero acts as one, large values clamp.
	always_comb begin
		eff_count = count_q;
		if (count_q == '0) begin
			eff_count = COUNT_W'(1);
		end
		if (count_q > COUNT_W'(TABLE_SIZE)) begin
			eff_count = COUNT_W'(TABLE_SIZE);
		end
	end

	// Group toggle; the round-robin index advances when the group rises.
	assign index_inc = {1'b0, index_q} + 4'd1;
	always_comb begin
		group_d = ~group_q;
		index_d = index_q;
		if (!group_q) begin
			index_d = (index_inc >= {1'b0, eff_count}) ? 3'd0 : index_inc[2:0];
		end
	end

	// Table lookup at the updated index, with entry zero for an out-of-table index.
	always_comb begin
		if (index_d >= 3'(TABLE_SIZE) || index_d >= 3'(NUM_TYPES)) begin
			table_type = types_q[0];
		end else begin
			table_type = types_q[index_d];
		end
	end

	// FIFO fill after this item.
	always_comb begin
		fill_d = fill_q;
		if (cmd.push_wr) begin
			fill_d = fill_q + FW'(1);
		end else if (cmd.pop) begin
			fill_d = fill_q - FW'(1);
		end
	end
	assign fill_ext = {5'd0, fill_d};

	// Item capture, scheduler state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= 1'b1;
			index_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.cmd_step) begin
				group_q <= group_d;
				index_q <= index_d;
			end
			if (cmd.push_wr) begin
				tail_q <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
			if (cmd.pop) begin
				head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.cmd_step || cmd.push_wr || cmd.push_drop) begin
			result_q.command_valid     <= cmd.cmd_step;
			result_q.motor_group       <= cmd.cmd_step ? group_d : 1'b0;
			result_q.requested_type    <= cmd.pop ? rd_data :
				(cmd.cmd_step ? table_type : '0);
			result_q.served_from_queue <= cmd.pop;
			result_q.push_dropped      <= cmd.push_drop;
			result_q.queue_level       <= fill_ext[LEVEL_W-1:0];
		end
	end

	// FIFO storage; the head entry is read when an item is taken.
	mdrs_ram #(
		.WIDTH (TYPE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo_ram (
		.clk     (clk),
		.wr_en   (cmd.push_wr),
		.wr_addr (tail_q),
		.wr_data (item_q.event_type),
		.rd_en   (cmd.capture),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	assign stat.op_is_cmd  = (item_q.operation == OP_COMMAND);
	assign stat.fifo_full  = (fill_q == FW'(QUEUE_DEPTH));
	assign stat.fifo_empty = (fill_q == '0);
	assign result          = result_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> (fill_q < FW'(QUEUE_DEPTH)))
		else $error("push written into a full FIFO");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (fill_q != '0) && cmd.cmd_step)
		else $error("pop from an empty FIFO or outside a command");
	a_tail_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (head_q == tail_q))
		else $error("empty FIFO with head and tail apart");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/motor_data_request_scheduler_unit.sv
// An accepted item is captured into the item register and executed in the
// execute state; its result is registered with done and held until the next.
// A new item is accepted only while idle; busy is high in the execute cycle.
// The receiver cannot stall: done is high for exactly one cycle per result.
// Reset (arst_n low) sets the group bit to one, clears the index and the FIFO
// pointers, and restores the configuration; FIFO contents are unknown until written.
`default_nettype none

module motor_data_request_scheduler_unit
	import mdrs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TABLE_SIZE  = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire mdrs_item_t           item,
	output logic                      done,
	output mdrs_result_t              result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	mdrs_cmd_t  cmd;
	mdrs_stat_t stat;

	// Configuration writes are taken only while no item is executing.
	assign cfg_ready = !busy;

	mdrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mdrs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TABLE_SIZE  (TABLE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result)
	);

endmodule

`default_nettype wire
